@@ rtl/core/assert_macros.svh @@
// Shared assertion macros for the record verifier.
// Each macro samples on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside of reset.
`define UPRV_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every edge, reset included.
`define UPRV_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/core/uprv_pkg.sv @@
package uprv_pkg;

   // Package layout
   localparam int unsigned HEADER_BYTES       = 5;
   localparam int unsigned CHECK_BYTES        = 2;
   localparam int unsigned VERSION_OFFSET_DEF = 7;
   localparam int unsigned VERSION_BYTES      = 12;

   // Reset values
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [31:0] FIRST_LEN_INIT = 32'h00FF_FFFF;

   // Register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_TYPE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_TYPE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_BASE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_BASE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILE_SIZE   = 3'd4;

   // Parser phases
   localparam logic [2:0] PH_HDR1  = 3'd0;
   localparam logic [2:0] PH_BODY1 = 3'd1;
   localparam logic [2:0] PH_HDR2  = 3'd2;
   localparam logic [2:0] PH_BODY2 = 3'd3;
   localparam logic [2:0] PH_TAIL  = 3'd4;

   // Status codes
   localparam logic [1:0] ST_BUSY     = 2'd0;
   localparam logic [1:0] ST_VALID    = 2'd1;
   localparam logic [1:0] ST_MISMATCH = 2'd2;
   localparam logic [1:0] ST_FORMAT   = 2'd3;

   typedef struct packed {
      logic        store_en;
      logic [31:0] store_addr;
      logic [7:0]  store_data;
      logic [1:0]  status;
      logic        finished;
      logic [31:0] version_major;
      logic [31:0] version_minor;
      logic [31:0] version_build;
   } result_type;

   // One byte of CRC-16/CCITT-FALSE (poly 0x1021, no reflection)
   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [7:0] x;
      x = c[15:8] ^ b;
      x = x ^ {4'b0000, x[7:4]};
      return {c[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
   endfunction

endpackage

@@ rtl/core/uprv_engine.sv @@
`include "assert_macros.svh"

module uprv_engine #(
   parameter int unsigned VERSION_OFFSET = uprv_pkg::VERSION_OFFSET_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [uprv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_wr_data,
   input  logic                             step_en,
   input  logic [7:0]                       data_byte,
   output uprv_pkg::result_type             res
);

   localparam logic [31:0] VerOfs   = 32'(VERSION_OFFSET);
   localparam logic [31:0] VerBytes = 32'(uprv_pkg::VERSION_BYTES);
   localparam logic [31:0] HdrBytes = 32'(uprv_pkg::HEADER_BYTES);
   localparam logic [31:0] ChkBytes = 32'(uprv_pkg::CHECK_BYTES);

   // Configuration registers
   logic [7:0]  first_type_ff, second_type_ff;
   logic [31:0] first_base_ff, second_base_ff, file_size_ff;

   // Parser state
   logic [2:0]  phase_ff, phase_in;
   logic [31:0] total_count_ff, total_count_in;
   logic [31:0] field_count_ff, field_count_in;
   logic [31:0] first_length_ff, first_length_in;
   logic [31:0] second_length_ff, second_length_in;
   logic [31:0] next_addr_ff, next_addr_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] first_crc_ff, first_crc_in;
   logic [15:0] stored_first_ff, stored_first_in;
   logic [15:0] stored_second_ff, stored_second_in;
   logic [31:0] ver_ff [3];
   logic [31:0] ver_in [3];
   logic        err_ff, err_in;

   // Per-byte helpers
   logic        is_second;
   logic [31:0] cur_len;
   logic [7:0]  exp_type;
   logic [31:0] fc_inc;
   logic [31:0] hdr_len;
   logic        type_bad;
   logic [15:0] crc_next;
   logic [31:0] ver_k;
   logic        ver_hit;
   logic [1:0]  ver_sel;
   logic [31:0] total_inc;
   logic        fin;

   assign is_second = (phase_ff == uprv_pkg::PH_HDR2) || (phase_ff == uprv_pkg::PH_BODY2);
   assign cur_len   = is_second ? second_length_ff : first_length_ff;
   assign exp_type  = is_second ? second_type_ff : first_type_ff;
   assign fc_inc    = field_count_ff + 32'd1;
   assign hdr_len   = (field_count_ff == '0) ? '0 : {cur_len[23:0], data_byte};
   assign type_bad  = (field_count_ff == '0) && (data_byte != exp_type);
   assign crc_next  = uprv_pkg::crc_byte(crc_ff, data_byte);
   assign ver_k     = total_count_ff - VerOfs;
   assign ver_hit   = !err_ff && (total_count_ff >= VerOfs) && (ver_k < VerBytes);
   assign ver_sel   = ver_k[3:2];
   assign total_inc = total_count_ff + 32'd1;
   assign fin       = total_inc >= file_size_ff;

   // Step the parser on one byte
   always_comb begin
      phase_in         = phase_ff;
      total_count_in   = total_count_ff;
      field_count_in   = field_count_ff;
      first_length_in  = first_length_ff;
      second_length_in = second_length_ff;
      next_addr_in     = next_addr_ff;
      crc_in           = crc_ff;
      first_crc_in     = first_crc_ff;
      stored_first_in  = stored_first_ff;
      stored_second_in = stored_second_ff;
      ver_in           = ver_ff;
      err_in           = err_ff;
      res              = '0;

      if (step_en) begin
         // capture version words by absolute position
         if (ver_hit) begin
            ver_in[ver_sel] = {ver_ff[ver_sel][23:0], data_byte};
         end

         if (!err_ff) begin
            unique case (phase_ff)
               uprv_pkg::PH_HDR1, uprv_pkg::PH_HDR2: begin
                  if (type_bad) begin
                     err_in = 1'b1;
                  end else begin
                     if (is_second) second_length_in = hdr_len;
                     else           first_length_in  = hdr_len;
                     field_count_in = fc_inc;
                     if (fc_inc >= HdrBytes) begin
                        if (hdr_len < ChkBytes) begin
                           err_in = 1'b1;
                        end else begin
                           field_count_in = '0;
                           next_addr_in   = is_second ? second_base_ff : first_base_ff;
                           crc_in         = uprv_pkg::CRC_INIT;
                           phase_in       = is_second ? uprv_pkg::PH_BODY2 : uprv_pkg::PH_BODY1;
                        end
                     end
                  end
               end
               uprv_pkg::PH_BODY1, uprv_pkg::PH_BODY2: begin
                  res.store_en   = 1'b1;
                  res.store_addr = next_addr_ff;
                  res.store_data = data_byte;
                  if (field_count_ff < ChkBytes) begin
                     if (is_second) stored_second_in = {stored_second_ff[7:0], data_byte};
                     else           stored_first_in  = {stored_first_ff[7:0], data_byte};
                  end else begin
                     crc_in = crc_next;
                  end
                  next_addr_in   = next_addr_ff + 32'd1;
                  field_count_in = fc_inc;
                  if (fc_inc >= cur_len) begin
                     field_count_in = '0;
                     if (is_second) begin
                        phase_in = uprv_pkg::PH_TAIL;
                     end else begin
                        first_crc_in = crc_in;
                        phase_in     = uprv_pkg::PH_HDR2;
                     end
                  end
               end
               default: ;
            endcase
         end

         total_count_in = total_inc;
         res.status     = err_in ? uprv_pkg::ST_FORMAT : uprv_pkg::ST_BUSY;
         if (fin) begin
            res.finished = 1'b1;
            if (err_in || (phase_in != uprv_pkg::PH_TAIL)) begin
               res.status = uprv_pkg::ST_FORMAT;
            end else if ((first_crc_in == stored_first_in) && (crc_in == stored_second_in)) begin
               res.status = uprv_pkg::ST_VALID;
            end else begin
               res.status = uprv_pkg::ST_MISMATCH;
            end
         end
         res.version_major = ver_in[0];
         res.version_minor = ver_in[1];
         res.version_build = ver_in[2];

         // drop all package state after the verdict
         if (fin) begin
            phase_in         = uprv_pkg::PH_HDR1;
            total_count_in   = '0;
            field_count_in   = '0;
            first_length_in  = uprv_pkg::FIRST_LEN_INIT;
            second_length_in = '0;
            next_addr_in     = '0;
            crc_in           = uprv_pkg::CRC_INIT;
            first_crc_in     = '0;
            stored_first_in  = '0;
            stored_second_in = '0;
            ver_in[0]        = '0;
            ver_in[1]        = '0;
            ver_in[2]        = '0;
            err_in           = 1'b0;
         end
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         first_type_ff  <= 8'd0;
         second_type_ff <= 8'd1;
         first_base_ff  <= '0;
         second_base_ff <= '0;
         file_size_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            uprv_pkg::CSR_FIRST_TYPE:  first_type_ff  <= csr_wr_data[7:0];
            uprv_pkg::CSR_SECOND_TYPE: second_type_ff <= csr_wr_data[7:0];
            uprv_pkg::CSR_FIRST_BASE:  first_base_ff  <= csr_wr_data;
            uprv_pkg::CSR_SECOND_BASE: second_base_ff <= csr_wr_data;
            uprv_pkg::CSR_FILE_SIZE:   file_size_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= uprv_pkg::PH_HDR1;
         total_count_ff   <= '0;
         field_count_ff   <= '0;
         first_length_ff  <= uprv_pkg::FIRST_LEN_INIT;
         second_length_ff <= '0;
         next_addr_ff     <= '0;
         crc_ff           <= uprv_pkg::CRC_INIT;
         first_crc_ff     <= '0;
         stored_first_ff  <= '0;
         stored_second_ff <= '0;
         ver_ff[0]        <= '0;
         ver_ff[1]        <= '0;
         ver_ff[2]        <= '0;
         err_ff           <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         total_count_ff   <= total_count_in;
         field_count_ff   <= field_count_in;
         first_length_ff  <= first_length_in;
         second_length_ff <= second_length_in;
         next_addr_ff     <= next_addr_in;
         crc_ff           <= crc_in;
         first_crc_ff     <= first_crc_in;
         stored_first_ff  <= stored_first_in;
         stored_second_ff <= stored_second_in;
         ver_ff           <= ver_in;
         err_ff           <= err_in;
      end
   end

   `UPRV_ASSERT(a_no_store_after_error, step_en && err_ff |-> !res.store_en, "store after format error")
   `UPRV_ASSERT(a_clear_after_verdict, step_en && res.finished |=> (total_count_ff == '0) && (phase_ff == uprv_pkg::PH_HDR1) && !err_ff, "state not cleared after verdict")
   `UPRV_ASSERT(a_body1_count, (phase_ff == uprv_pkg::PH_BODY1) |-> (field_count_ff < first_length_ff), "first body count past length")

endmodule

@@ rtl/core/uprv_out_reg.sv @@
module uprv_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  uprv_pkg::result_type res,
   input  logic                 rsp_stall,
   output logic                 ready,
   output logic                 rsp_valid,
   output uprv_pkg::result_type res_out
);

   logic                 valid_ff, valid_in;
   uprv_pkg::result_type res_ff;

   // Take a new result when empty or when the held one transfers
   assign ready     = !valid_ff || !rsp_stall;
   assign valid_in  = load || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign res_out   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until the next load
   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

endmodule

@@ rtl/core/update_package_record_verifier_unit.sv @@
// Update-package record verifier.
// The req channel carries one package byte per transfer (req_data_byte);
// the rsp channel returns exactly one result per byte, in order: the flash
// store request for body bytes, the running status, the version words and,
// on the byte that reaches file_size, the finished flag with the verdict.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low. Registers are written through csr_wr_en/csr_index/csr_wr_data;
// the user must write them only while no byte is in flight; the block does not enforce it.
// A byte lands in the input register, then the parser step runs
// combinationally into the result register. Throughput is one byte per
// cycle while rsp_stall is low; the parser state update (CRC byte step and
// length compare) is the feedback loop that sets it.
// When rsp_stall holds a result, one more byte is still taken into the input
// register; req_stall rises only when both registers are full.
// A synchronous reset empties both registers, restores the register defaults
// and returns the parser to the first record header.
`include "assert_macros.svh"

module update_package_record_verifier_unit #(
   parameter int unsigned VERSION_OFFSET = uprv_pkg::VERSION_OFFSET_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [uprv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_data_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_store_en,
   output logic [31:0]                      rsp_store_addr,
   output logic [7:0]                       rsp_store_data,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_finished,
   output logic [31:0]                      rsp_version_major,
   output logic [31:0]                      rsp_version_minor,
   output logic [31:0]                      rsp_version_build
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 out_ready;
   logic                 advance;
   logic                 req_take;
   uprv_pkg::result_type step_res;
   uprv_pkg::result_type out_res;

   // Move the held byte on when the result register can take it
   assign advance     = in_valid_ff && out_ready;
   assign req_stall   = in_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
      end
   end

   uprv_engine #(
      .VERSION_OFFSET(VERSION_OFFSET)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .step_en     (advance),
      .data_byte   (in_byte_ff),
      .res         (step_res)
   );

   uprv_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .res       (step_res),
      .rsp_stall (rsp_stall),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .res_out   (out_res)
   );

   // Unpack the result register onto the ports
   assign rsp_store_en      = out_res.store_en;
   assign rsp_store_addr    = out_res.store_addr;
   assign rsp_store_data    = out_res.store_data;
   assign rsp_status        = out_res.status;
   assign rsp_finished      = out_res.finished;
   assign rsp_version_major = out_res.version_major;
   assign rsp_version_minor = out_res.version_minor;
   assign rsp_version_build = out_res.version_build;

   `UPRV_ASSERT(a_take_lands, req_take |=> in_valid_ff, "transferred byte not held")
   `UPRV_ASSERT(a_hold_on_full, in_valid_ff && rsp_valid && rsp_stall |-> req_stall, "input taken with both stages full")

endmodule
